>>> hw/rtl/tmprof_pkg.sv
// Types, constants and microcode program of the trapezoid motion profile block.
package tmprof_pkg;

  // Configuration register indexes and reset values
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegMaxAccel    = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMaxVelocity = 2'd1;
  localparam logic [CfgIdxW-1:0] RegLoopPeriod  = 2'd2;

  localparam logic [30:0] MaxAccelRst    = 31'd6553600;
  localparam logic [30:0] MaxVelocityRst = 31'd655360;
  localparam logic [31:0] LoopPeriodRst  = 32'd4294967;

  // Braking term saturates here: anything at or above it decides the same way
  localparam logic [33:0] BrakeSat = 34'h2_0000_0000;

  // Signed 32-bit limits for the reference, held in 34 bits
  localparam logic signed [33:0] RefHi = 34'sd2147483647;
  localparam logic signed [33:0] RefLo = -34'sd2147483648;

  // Divider: 33 quotient bits, one per step
  localparam int unsigned DivSteps = 33;
  localparam int unsigned CntW     = $clog2(DivSteps);
  localparam logic [CntW-1:0] DivLast = CntW'(DivSteps - 1);

  // Program store
  localparam int unsigned NumSteps = 16;
  localparam int unsigned PcW      = $clog2(NumSteps);
  localparam logic [PcW-1:0] StepFirst = 4'd0;
  localparam logic [PcW-1:0] StepDiv   = 4'd9;

  // Datapath operation of a step
  typedef enum logic [3:0] {
    OP_ERR,     // error and direction
    OP_FULL,    // latch A*dt
    OP_QHI,     // q = hi(A*dt)*dt
    OP_QADD,    // q += lo(A*dt)*dt >> 32
    OP_VELO,    // trial velocity with full acceleration
    OP_MAG,     // magnitude of trial velocity
    OP_THR,     // snap threshold
    OP_SQ,      // divider set-up from v^2
    OP_TDT,     // |v|*dt of trial velocity
    OP_DIV,     // one restoring division step
    OP_STOP,    // stopping distance
    OP_DECIDE,  // acceleration sign
    OP_VNEW,    // new velocity
    OP_MAGN,    // magnitude of new velocity
    OP_SNAP,    // snap test
    OP_FINISH   // new reference, state and result word
  } op_e;

  // Multiplier operand selection
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_A_DT,
    MUL_PHI_DT,
    MUL_FLO_DT,
    MUL_MAG_SQ,
    MUL_MAG_DT
  } mul_e;

  // Sequencing
  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_LOOP,
    JMP_END
  } jmp_e;

  typedef struct packed {
    op_e              op;
    mul_e             mul;
    jmp_e             jmp;
    logic [PcW-1:0]   target;
  } ctrl_t;

  // Control word ROM
  function automatic ctrl_t ucode(input logic [PcW-1:0] pc);
    ctrl_t w;
    w = '{op: OP_FINISH, mul: MUL_NONE, jmp: JMP_NEXT, target: StepFirst};
    unique case (pc)
      4'd0:  w = '{op: OP_ERR,    mul: MUL_A_DT,   jmp: JMP_NEXT, target: StepFirst};
      4'd1:  w = '{op: OP_FULL,   mul: MUL_PHI_DT, jmp: JMP_NEXT, target: StepFirst};
      4'd2:  w = '{op: OP_QHI,    mul: MUL_FLO_DT, jmp: JMP_NEXT, target: StepFirst};
      4'd3:  w = '{op: OP_QADD,   mul: MUL_NONE,   jmp: JMP_NEXT, target: StepFirst};
      4'd4:  w = '{op: OP_VELO,   mul: MUL_NONE,   jmp: JMP_NEXT, target: StepFirst};
      4'd5:  w = '{op: OP_MAG,    mul: MUL_NONE,   jmp: JMP_NEXT, target: StepFirst};
      4'd6:  w = '{op: OP_THR,    mul: MUL_MAG_SQ, jmp: JMP_NEXT, target: StepFirst};
      4'd7:  w = '{op: OP_SQ,     mul: MUL_MAG_DT, jmp: JMP_NEXT, target: StepFirst};
      4'd8:  w = '{op: OP_TDT,    mul: MUL_NONE,   jmp: JMP_NEXT, target: StepFirst};
      4'd9:  w = '{op: OP_DIV,    mul: MUL_NONE,   jmp: JMP_LOOP, target: StepDiv};
      4'd10: w = '{op: OP_STOP,   mul: MUL_NONE,   jmp: JMP_NEXT, target: StepFirst};
      4'd11: w = '{op: OP_DECIDE, mul: MUL_NONE,   jmp: JMP_NEXT, target: StepFirst};
      4'd12: w = '{op: OP_VNEW,   mul: MUL_NONE,   jmp: JMP_NEXT, target: StepFirst};
      4'd13: w = '{op: OP_MAGN,   mul: MUL_NONE,   jmp: JMP_NEXT, target: StepFirst};
      4'd14: w = '{op: OP_SNAP,   mul: MUL_MAG_DT, jmp: JMP_NEXT, target: StepFirst};
      4'd15: w = '{op: OP_FINISH, mul: MUL_NONE,   jmp: JMP_END,  target: StepFirst};
    endcase
    return w;
  endfunction

  // vel +/- dv, clamped to +/- vmax
  function automatic logic signed [31:0] clamp_vel(input logic signed [31:0] vel,
                                                   input logic [30:0] dv,
                                                   input logic add,
                                                   input logic [30:0] vmax);
    logic signed [32:0] sum;
    logic signed [32:0] lim;
    logic signed [31:0] res;
    sum = {vel[31], vel} + (add ? {2'b00, dv} : -{2'b00, dv});
    lim = {2'b00, vmax};
    if (sum > lim) begin
      res = {1'b0, vmax};
    end else if (sum < -lim) begin
      res = -{1'b0, vmax};
    end else begin
      res = sum[31:0];
    end
    return res;
  endfunction

endpackage

>>> hw/rtl/trapezoid_motion_profile.sv
// Top level: microcoded trapezoid velocity profile generator, Q16.16.
//
//  channel | signals                                    | dir | word
//  --------+--------------------------------------------+-----+--------------------------
//  in      | in_valid_i, in_ready_o, target_position_i  | in  | one target per tick
//  out     | out_valid_o, out_ready_i, *_out_o, snapped | out | reference, vel, accel, snap
//  cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i/data | in  | register write
//
// One word passes from acceptance to the result register through 15 single
// steps of the program plus 33 passes of the restoring divider step that
// forms v^2/(2A), one quotient bit per cycle. Words are processed one at a
// time; the next word is taken as soon as the program ends, even while the
// last result waits. The final step stalls only if that result is still
// unread. Reset clears the position and velocity and loads register defaults.
module trapezoid_motion_profile (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [31:0]                   target_position_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [31:0]                   reference_out_o,
  output logic signed [31:0]                   velocity_out_o,
  output logic signed [31:0]                   accel_out_o,
  output logic                                 snapped_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [tmprof_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [31:0]                          cfg_data_i
);

  // Configuration
  logic [30:0] max_accel_q, max_velocity_q;
  logic [31:0] loop_period_q;

  // Sequencer
  logic                          busy_q, busy_d;
  logic [tmprof_pkg::PcW-1:0]    pc_q, pc_d;
  logic [tmprof_pkg::CntW-1:0]   cnt_q, cnt_d;
  tmprof_pkg::ctrl_t             ctrl;
  logic                          advance, step_en;

  // Profile state
  logic signed [31:0] ref_q, ref_d, vel_q, vel_d;

  // Datapath
  logic signed [31:0] cmd_q;
  logic [63:0]        prod_q, prod_d;
  logic [31:0]        mul_a, mul_b;
  logic [62:0]        full_q, full_d;
  logic signed [32:0] err_q, err_d;
  logic               up_q, up_d;
  logic [63:0]        qq_q, qq_d;
  logic signed [31:0] velo_q, velo_d;
  logic [31:0]        mag_q, mag_d;
  logic               neg_q, neg_d;
  logic [32:0]        thr_q, thr_d;
  logic [31:0]        rem_q, rem_d;
  logic [32:0]        quo_q, quo_d;
  logic               sat_q, sat_d;
  logic [31:0]        tdt_q, tdt_d;
  logic signed [34:0] stop_q, stop_d;
  logic               accpos_q, accpos_d;
  logic signed [31:0] vnew_q, vnew_d;
  logic               snap_q, snap_d;

  // Result register
  logic               out_valid_q, out_valid_d;
  logic signed [31:0] ref_out_q, ref_out_d;
  logic signed [31:0] vel_out_q, vel_out_d;
  logic signed [31:0] acc_out_q, acc_out_d;
  logic               snap_out_q, snap_out_d;

  // Shared terms
  logic [30:0]        dv;
  logic               a_zero;
  logic [64:0]        thr_sum;
  logic [32:0]        div_t, div_d, div_diff;
  logic               div_ge;
  logic [33:0]        brake;
  logic signed [34:0] brake_s, tdt_s, err_x;
  logic               flip;
  logic [32:0]        abs_err;
  logic [31:0]        t2;
  logic signed [33:0] ref_sum;

  assign ctrl    = tmprof_pkg::ucode(pc_q);
  assign advance = !(ctrl.op == tmprof_pkg::OP_FINISH && out_valid_q && !out_ready_i);
  assign step_en = busy_q && advance;

  assign in_ready_o  = !busy_q;
  assign cfg_ready_o = 1'b1;

  assign dv     = full_q[62:32];
  assign a_zero = (max_accel_q == '0);

  // Next step
  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    if (!busy_q) begin
      if (in_valid_i) begin
        busy_d = 1'b1;
        pc_d   = tmprof_pkg::StepFirst;
      end
    end else if (advance) begin
      unique case (ctrl.jmp)
        tmprof_pkg::JMP_NEXT: pc_d = pc_q + tmprof_pkg::PcW'(1);
        tmprof_pkg::JMP_LOOP: pc_d = (cnt_q != '0) ? ctrl.target
                                                   : pc_q + tmprof_pkg::PcW'(1);
        tmprof_pkg::JMP_END: begin
          busy_d = 1'b0;
          pc_d   = tmprof_pkg::StepFirst;
        end
        default: pc_d = tmprof_pkg::StepFirst;
      endcase
    end
  end

  // Multiplier operands
  always_comb begin
    unique case (ctrl.mul)
      tmprof_pkg::MUL_A_DT: begin
        mul_a = {1'b0, max_accel_q};
        mul_b = loop_period_q;
      end
      tmprof_pkg::MUL_PHI_DT: begin
        mul_a = {1'b0, prod_q[62:32]};
        mul_b = loop_period_q;
      end
      tmprof_pkg::MUL_FLO_DT: begin
        mul_a = full_q[31:0];
        mul_b = loop_period_q;
      end
      tmprof_pkg::MUL_MAG_SQ: begin
        mul_a = mag_q;
        mul_b = mag_q;
      end
      tmprof_pkg::MUL_MAG_DT: begin
        mul_a = mag_q;
        mul_b = loop_period_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Shared arithmetic terms
  always_comb begin
    thr_sum  = {1'b0, qq_q} + {2'b00, qq_q[63:1]};
    div_t    = {rem_q, quo_q[32]};
    div_d    = {1'b0, max_accel_q, 1'b0};
    div_ge   = (div_t >= div_d);
    div_diff = div_t - div_d;
    if (a_zero) begin
      brake = '0;
    end else if (sat_q) begin
      brake = tmprof_pkg::BrakeSat;
    end else begin
      brake = {1'b0, quo_q};
    end
    brake_s = {1'b0, brake};
    tdt_s   = neg_q ? -{3'b000, tdt_q} : {3'b000, tdt_q};
    err_x   = {{2{err_q[32]}}, err_q};
    flip    = up_q ? (err_x < stop_q && vel_q > 32'sd0)
                   : (err_x > stop_q && vel_q < 32'sd0);
    abs_err = err_q[32] ? -err_q : err_q;
    t2      = prod_q[63:32];
    ref_sum = {{2{ref_q[31]}}, ref_q} + (neg_q ? -{2'b00, t2} : {2'b00, t2});
  end

  // Datapath step
  always_comb begin
    prod_d   = prod_q;
    full_d   = full_q;
    err_d    = err_q;
    up_d     = up_q;
    qq_d     = qq_q;
    velo_d   = velo_q;
    mag_d    = mag_q;
    neg_d    = neg_q;
    thr_d    = thr_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    sat_d    = sat_q;
    cnt_d    = cnt_q;
    tdt_d    = tdt_q;
    stop_d   = stop_q;
    accpos_d = accpos_q;
    vnew_d   = vnew_q;
    snap_d   = snap_q;
    ref_d    = ref_q;
    vel_d    = vel_q;
    ref_out_d  = ref_out_q;
    vel_out_d  = vel_out_q;
    acc_out_d  = acc_out_q;
    snap_out_d = snap_out_q;
    if (step_en) begin
      if (ctrl.mul != tmprof_pkg::MUL_NONE) begin
        prod_d = 64'(mul_a) * 64'(mul_b);
      end
      unique case (ctrl.op)
        tmprof_pkg::OP_ERR: begin
          err_d = {cmd_q[31], cmd_q} - {ref_q[31], ref_q};
          up_d  = (cmd_q > ref_q);
        end
        tmprof_pkg::OP_FULL: full_d = prod_q[62:0];
        tmprof_pkg::OP_QHI:  qq_d   = prod_q;
        tmprof_pkg::OP_QADD: qq_d   = qq_q + {32'b0, prod_q[63:32]};
        tmprof_pkg::OP_VELO: velo_d = tmprof_pkg::clamp_vel(vel_q, dv, up_q, max_velocity_q);
        tmprof_pkg::OP_MAG: begin
          mag_d = velo_q[31] ? 32'(-velo_q) : velo_q;
          neg_d = velo_q[31];
        end
        tmprof_pkg::OP_THR: thr_d = thr_sum[64:32];
        tmprof_pkg::OP_SQ: begin
          // v^2 / 2A: top bits seed the remainder; saturation is flagged when they reach A
          sat_d = ({3'b000, prod_q[61:34]} >= max_accel_q);
          rem_d = {3'b000, prod_q[61:33]};
          quo_d = prod_q[32:0];
          cnt_d = tmprof_pkg::DivLast;
        end
        tmprof_pkg::OP_TDT: tdt_d = prod_q[63:32];
        tmprof_pkg::OP_DIV: begin
          rem_d = div_ge ? div_diff[31:0] : div_t[31:0];
          quo_d = {quo_q[31:0], div_ge};
          if (cnt_q != '0) begin
            cnt_d = cnt_q - tmprof_pkg::CntW'(1);
          end
        end
        tmprof_pkg::OP_STOP:   stop_d = up_q ? brake_s + tdt_s : tdt_s - brake_s;
        tmprof_pkg::OP_DECIDE: accpos_d = a_zero | (up_q ^ flip);
        tmprof_pkg::OP_VNEW:
          vnew_d = tmprof_pkg::clamp_vel(vel_q, dv, accpos_q, max_velocity_q);
        tmprof_pkg::OP_MAGN: begin
          mag_d = vnew_q[31] ? 32'(-vnew_q) : vnew_q;
          neg_d = vnew_q[31];
        end
        tmprof_pkg::OP_SNAP: snap_d = (mag_q <= {1'b0, dv}) && (abs_err < thr_q);
        tmprof_pkg::OP_FINISH: begin
          // Reference either snaps or moves by v*dt with saturation
          if (snap_q) begin
            ref_d = cmd_q;
          end else if (ref_sum > tmprof_pkg::RefHi) begin
            ref_d = tmprof_pkg::RefHi[31:0];
          end else if (ref_sum < tmprof_pkg::RefLo) begin
            ref_d = tmprof_pkg::RefLo[31:0];
          end else begin
            ref_d = ref_sum[31:0];
          end
          vel_d      = vnew_q;
          ref_out_d  = ref_d;
          vel_out_d  = vnew_q;
          acc_out_d  = accpos_q ? {1'b0, max_accel_q} : -{1'b0, max_accel_q};
          snap_out_d = snap_q;
        end
      endcase
    end
  end

  // Result valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (step_en && ctrl.op == tmprof_pkg::OP_FINISH) begin
      out_valid_d = 1'b1;
    end
  end

  // Control, configuration and profile state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q         <= 1'b0;
      pc_q           <= tmprof_pkg::StepFirst;
      cnt_q          <= '0;
      out_valid_q    <= 1'b0;
      ref_q          <= '0;
      vel_q          <= '0;
      max_accel_q    <= tmprof_pkg::MaxAccelRst;
      max_velocity_q <= tmprof_pkg::MaxVelocityRst;
      loop_period_q  <= tmprof_pkg::LoopPeriodRst;
    end else begin
      busy_q      <= busy_d;
      pc_q        <= pc_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      ref_q       <= ref_d;
      vel_q       <= vel_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == tmprof_pkg::RegMaxAccel) begin
          max_accel_q <= cfg_data_i[30:0];
        end else if (cfg_index_i == tmprof_pkg::RegMaxVelocity) begin
          max_velocity_q <= cfg_data_i[30:0];
        end else if (cfg_index_i == tmprof_pkg::RegLoopPeriod) begin
          loop_period_q <= cfg_data_i;
        end
      end
    end
  end

  // Datapath and result payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !busy_q) begin
      cmd_q <= target_position_i;
    end
    prod_q     <= prod_d;
    full_q     <= full_d;
    err_q      <= err_d;
    up_q       <= up_d;
    qq_q       <= qq_d;
    velo_q     <= velo_d;
    mag_q      <= mag_d;
    neg_q      <= neg_d;
    thr_q      <= thr_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    sat_q      <= sat_d;
    tdt_q      <= tdt_d;
    stop_q     <= stop_d;
    accpos_q   <= accpos_d;
    vnew_q     <= vnew_d;
    snap_q     <= snap_d;
    ref_out_q  <= ref_out_d;
    vel_out_q  <= vel_out_d;
    acc_out_q  <= acc_out_d;
    snap_out_q <= snap_out_d;
  end

  assign out_valid_o     = out_valid_q;
  assign reference_out_o = ref_out_q;
  assign velocity_out_o  = vel_out_q;
  assign accel_out_o     = acc_out_q;
  assign snapped_o       = snap_out_q;

  // An accepted word starts the program at its first step
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> busy_q && pc_q == tmprof_pkg::StepFirst)
    else $error("program did not start on accepted word");

  // A result appears only from the final step
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(busy_q && ctrl.op == tmprof_pkg::OP_FINISH))
    else $error("result valid without final step");

  // Divider loops on itself and counts down
  a_div_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && ctrl.op == tmprof_pkg::OP_DIV && cnt_q != '0
      |=> pc_q == tmprof_pkg::StepDiv && cnt_q == $past(cnt_q - tmprof_pkg::CntW'(1)))
    else $error("divider loop broken");

endmodule
